// ----- hw/rtl/mcr_pkg.sv -----
package mcr_pkg;

    localparam int DEF_MAX_RADIUS = 88;
    localparam int DEF_COORD_BITS = 11;

    localparam int RADIUS_BITS = 7;
    localparam int STEP_BITS   = 7;
    localparam int DEC_BITS    = 9;
    localparam int OUT_BITS    = 12;
    localparam int MAX_STEPS   = 64;
    localparam int CNT_BITS    = $clog2(MAX_STEPS + 1);

    typedef struct packed {
        logic load;
        logic step;
    } mcr_cmd_t;

    typedef struct packed {
        logic last;
    } mcr_sts_t;

endpackage

// ----- hw/rtl/mcr_ctrl.sv -----
module mcr_ctrl
    import mcr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output mcr_cmd_t cmd,
    input  mcr_sts_t sts
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic emit;

    // a step fires when the output register is empty or being drained
    assign emit = (state_reg == ST_RUN) && (!out_valid_reg || !out_stall);

    assign cmd.load = in_valid && (state_reg == ST_IDLE);
    assign cmd.step = emit;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/mcr_datapath.sv -----
module mcr_datapath
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcr_cmd_t                      cmd,
    output mcr_sts_t                      sts,
    input  logic signed [COORD_BITS-1:0]  centre_x,
    input  logic signed [COORD_BITS-1:0]  centre_y,
    input  logic [RADIUS_BITS-1:0]        circle_radius,
    output logic signed [OUT_BITS-1:0]    cx_plus_x,
    output logic signed [OUT_BITS-1:0]    cx_minus_x,
    output logic signed [OUT_BITS-1:0]    cy_plus_y,
    output logic signed [OUT_BITS-1:0]    cy_minus_y,
    output logic signed [OUT_BITS-1:0]    cx_plus_y,
    output logic signed [OUT_BITS-1:0]    cx_minus_y,
    output logic signed [OUT_BITS-1:0]    cy_plus_x,
    output logic signed [OUT_BITS-1:0]    cy_minus_x,
    output logic                          final_step
);

    localparam int SUM_W = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
    localparam logic [RADIUS_BITS-1:0] RAD_LIM = RADIUS_BITS'(MAX_RADIUS);
    localparam logic [CNT_BITS-1:0]    CNT_LIM = CNT_BITS'(MAX_STEPS);

    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic [STEP_BITS-1:0]         x_reg;
    logic [STEP_BITS-1:0]         x_next;
    logic [STEP_BITS-1:0]         y_reg;
    logic [STEP_BITS-1:0]         y_next;
    logic signed [DEC_BITS-1:0]   dec_reg;
    logic signed [DEC_BITS-1:0]   dec_next;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic [CNT_BITS-1:0]          cnt_next;
    logic [RADIUS_BITS-1:0]       rad_sat;

    logic                         dec_neg;
    logic signed [STEP_BITS+1:0]  nx_s;
    logic signed [STEP_BITS+1:0]  ny_s;
    logic signed [STEP_BITS+1:0]  inc_s;
    logic signed [DEC_BITS+1:0]   dec_sum;
    logic                         last;

    logic signed [SUM_W-1:0]      cx_ext;
    logic signed [SUM_W-1:0]      cy_ext;
    logic signed [SUM_W-1:0]      x_ext;
    logic signed [SUM_W-1:0]      y_ext;
    logic signed [SUM_W-1:0]      s_cx_px;
    logic signed [SUM_W-1:0]      s_cx_mx;
    logic signed [SUM_W-1:0]      s_cy_py;
    logic signed [SUM_W-1:0]      s_cy_my;
    logic signed [SUM_W-1:0]      s_cx_py;
    logic signed [SUM_W-1:0]      s_cx_my;
    logic signed [SUM_W-1:0]      s_cy_px;
    logic signed [SUM_W-1:0]      s_cy_mx;

    assign rad_sat = (circle_radius > RAD_LIM) ? RAD_LIM : circle_radius;

    // midpoint update: y drops when the decision is non-negative
    assign dec_neg = dec_reg[DEC_BITS-1];
    assign nx_s    = $signed({2'b00, x_reg}) + $signed((STEP_BITS + 2)'(1));
    assign ny_s    = $signed({2'b00, y_reg}) - $signed({{(STEP_BITS + 1){1'b0}}, ~dec_neg});
    assign inc_s   = dec_neg ? nx_s : (nx_s - ny_s);
    assign dec_sum = $signed((DEC_BITS + 2)'(dec_reg))
                   + $signed({{(DEC_BITS - STEP_BITS - 1){inc_s[STEP_BITS+1]}}, inc_s, 1'b1});
    assign cnt_next = cnt_reg + CNT_BITS'(1);
    assign last     = (nx_s > ny_s) || (cnt_next >= CNT_LIM);
    assign sts.last = last;

    assign x_next   = nx_s[STEP_BITS-1:0];
    assign y_next   = ny_s[STEP_BITS-1:0];
    assign dec_next = dec_sum[DEC_BITS-1:0];

    // coordinates wrap to the output width
    assign cx_ext  = SUM_W'(cx_reg);
    assign cy_ext  = SUM_W'(cy_reg);
    assign x_ext   = $signed(SUM_W'(x_reg));
    assign y_ext   = $signed(SUM_W'(y_reg));
    assign s_cx_px = cx_ext + x_ext;
    assign s_cx_mx = cx_ext - x_ext;
    assign s_cy_py = cy_ext + y_ext;
    assign s_cy_my = cy_ext - y_ext;
    assign s_cx_py = cx_ext + y_ext;
    assign s_cx_my = cx_ext - y_ext;
    assign s_cy_px = cy_ext + x_ext;
    assign s_cy_mx = cy_ext - x_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= centre_x;
            cy_reg  <= centre_y;
            x_reg   <= '0;
            y_reg   <= STEP_BITS'(rad_sat);
            dec_reg <= $signed(DEC_BITS'(1)) - $signed({{(DEC_BITS - RADIUS_BITS){1'b0}}, rad_sat});
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            dec_reg <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            cx_plus_x  <= s_cx_px[OUT_BITS-1:0];
            cx_minus_x <= s_cx_mx[OUT_BITS-1:0];
            cy_plus_y  <= s_cy_py[OUT_BITS-1:0];
            cy_minus_y <= s_cy_my[OUT_BITS-1:0];
            cx_plus_y  <= s_cx_py[OUT_BITS-1:0];
            cx_minus_y <= s_cx_my[OUT_BITS-1:0];
            cy_plus_x  <= s_cy_px[OUT_BITS-1:0];
            cy_minus_x <= s_cy_mx[OUT_BITS-1:0];
            final_step <= last;
        end
    end

endmodule

// ----- hw/rtl/midpoint_circle_rasterizer.sv -----
// channel | signals                                   | beat
// --------+-------------------------------------------+---------------------------
// in      | in_valid, in_stall, centre_x/y, radius    | one circle request
// out     | out_valid, out_stall, eight coords, final | one octant step, 1..64/circle
//
// each request is loaded while idle, then one beat per cycle while out_stall is low;
// a circle of radius r gives about r/sqrt(2)+1 beats, at most 64, set by the
// single step unit
// the next request is taken the cycle after the final beat is produced,
// while that beat may still sit in the output register
// reset returns the controller to idle with no beat pending
// out_stall freezes a held beat in the output register and the walk in place
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  centre_x,
    input  logic signed [COORD_BITS-1:0]  centre_y,
    input  logic [RADIUS_BITS-1:0]        circle_radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_BITS-1:0]    cx_plus_x,
    output logic signed [OUT_BITS-1:0]    cx_minus_x,
    output logic signed [OUT_BITS-1:0]    cy_plus_y,
    output logic signed [OUT_BITS-1:0]    cy_minus_y,
    output logic signed [OUT_BITS-1:0]    cx_plus_y,
    output logic signed [OUT_BITS-1:0]    cx_minus_y,
    output logic signed [OUT_BITS-1:0]    cy_plus_x,
    output logic signed [OUT_BITS-1:0]    cy_minus_x,
    output logic                          final_step
);

    mcr_cmd_t cmd;
    mcr_sts_t sts;

    mcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mcr_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .circle_radius (circle_radius),
        .cx_plus_x     (cx_plus_x),
        .cx_minus_x    (cx_minus_x),
        .cy_plus_y     (cy_plus_y),
        .cy_minus_y    (cy_minus_y),
        .cx_plus_y     (cx_plus_y),
        .cx_minus_y    (cx_minus_y),
        .cy_plus_x     (cy_plus_x),
        .cy_minus_x    (cy_minus_x),
        .final_step    (final_step)
    );

    // an accepted request keeps the input closed while its walk runs
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a request");

    // a beat that is not the last of its circle implies the walk is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !final_step |-> in_stall)
        else $error("mid-circle beat while idle");

    // a stalled beat stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({cx_plus_x, cx_minus_x, cy_plus_y, cy_minus_y})
            && $stable({cx_plus_y, cx_minus_y, cy_plus_x, cy_minus_x, final_step}))
        else $error("stalled beat changed");

endmodule

// ----- test/octant_checker.sv -----
`timescale 1ns / 100ps
module octant_checker
    import mcr_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic signed [DEF_COORD_BITS-1:0] centre_x,
    input  logic signed [DEF_COORD_BITS-1:0] centre_y,
    input  logic [RADIUS_BITS-1:0]           circle_radius,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic signed [OUT_BITS-1:0]       cx_plus_x,
    input  logic signed [OUT_BITS-1:0]       cx_minus_x,
    input  logic signed [OUT_BITS-1:0]       cy_plus_y,
    input  logic signed [OUT_BITS-1:0]       cy_minus_y,
    input  logic signed [OUT_BITS-1:0]       cx_plus_y,
    input  logic signed [OUT_BITS-1:0]       cx_minus_y,
    input  logic signed [OUT_BITS-1:0]       cy_plus_x,
    input  logic signed [OUT_BITS-1:0]       cy_minus_x,
    input  logic                             final_step,
    output int                               fails,
    output int                               pending,
    output int                               beats_checked
);

    localparam int PRINT_CAP = 60;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] xpx;
        logic signed [OUT_BITS-1:0] xmx;
        logic signed [OUT_BITS-1:0] ypy;
        logic signed [OUT_BITS-1:0] ymy;
        logic signed [OUT_BITS-1:0] xpy;
        logic signed [OUT_BITS-1:0] xmy;
        logic signed [OUT_BITS-1:0] ypx;
        logic signed [OUT_BITS-1:0] ymx;
        logic                       last;
    } octant_pts_t;

    octant_pts_t octant_q[$];

    initial
    begin
        fails         = 0;
        pending       = 0;
        beats_checked = 0;
    end

    task automatic report_error(input string msg);
        if (fails < PRINT_CAP)
            $display("%0t octant_checker: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input logic [OUT_BITS-1:0] got,
                               input logic [OUT_BITS-1:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s got %0d want %0d", beats_checked, name,
                                   $signed(got), $signed(want)));
    endtask

    // walk the first octant of one circle and queue every point set it yields
    task automatic plot_octant(input logic signed [DEF_COORD_BITS-1:0] cx,
                               input logic signed [DEF_COORD_BITS-1:0] cy,
                               input logic [RADIUS_BITS-1:0] rad);
        int          r;
        int          px;
        int          py;
        int          dec;
        int          nx;
        int          ny;
        int          steps;
        bit          done;
        octant_pts_t pt;
        r     = (rad > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(rad);
        px    = 0;
        py    = r;
        dec   = 1 - r;
        steps = 0;
        done  = 1'b0;
        while (!done)
        begin
            pt.xpx = OUT_BITS'(cx + px);
            pt.xmx = OUT_BITS'(cx - px);
            pt.ypy = OUT_BITS'(cy + py);
            pt.ymy = OUT_BITS'(cy - py);
            pt.xpy = OUT_BITS'(cx + py);
            pt.xmy = OUT_BITS'(cx - py);
            pt.ypx = OUT_BITS'(cy + px);
            pt.ymx = OUT_BITS'(cy - px);
            nx = px + 1;
            ny = py;
            if (dec < 0)
                dec = dec + 2 * nx + 1;
            else
            begin
                ny  = py - 1;
                dec = dec + 2 * (nx - ny) + 1;
            end
            steps++;
            // step budget caps the walk as the design's step counter does
            done    = (nx > ny) || (steps >= MAX_STEPS);
            pt.last = done;
            octant_q.push_back(pt);
            px = nx;
            py = ny;
        end
    endtask

    always @(posedge clk)
    begin : watch
        octant_pts_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                beats_checked++;
                if (octant_q.size() == 0)
                    report_error("output beat with no point set expected");
                else
                begin
                    want = octant_q.pop_front();
                    check_field("cx_plus_x",  cx_plus_x,  want.xpx);
                    check_field("cx_minus_x", cx_minus_x, want.xmx);
                    check_field("cy_plus_y",  cy_plus_y,  want.ypy);
                    check_field("cy_minus_y", cy_minus_y, want.ymy);
                    check_field("cx_plus_y",  cx_plus_y,  want.xpy);
                    check_field("cx_minus_y", cx_minus_y, want.xmy);
                    check_field("cy_plus_x",  cy_plus_x,  want.ypx);
                    check_field("cy_minus_x", cy_minus_x, want.ymx);
                    check_field("final_step", {{(OUT_BITS-1){1'b0}}, final_step},
                                {{(OUT_BITS-1){1'b0}}, want.last});
                end
            end
            if (in_valid && !in_stall)
                plot_octant(centre_x, centre_y, circle_radius);
            pending <= octant_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
module tb
    import mcr_pkg::*;
();

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYC   = 7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYC    = 400;
    localparam int SETTLE_CYC  = 64;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             in_valid      = 1'b0;
    logic                             in_stall;
    logic signed [DEF_COORD_BITS-1:0] centre_x      = '0;
    logic signed [DEF_COORD_BITS-1:0] centre_y      = '0;
    logic [RADIUS_BITS-1:0]           circle_radius = '0;
    logic                             out_valid;
    logic                             out_stall     = 1'b0;
    logic signed [OUT_BITS-1:0]       cx_plus_x;
    logic signed [OUT_BITS-1:0]       cx_minus_x;
    logic signed [OUT_BITS-1:0]       cy_plus_y;
    logic signed [OUT_BITS-1:0]       cy_minus_y;
    logic signed [OUT_BITS-1:0]       cx_plus_y;
    logic signed [OUT_BITS-1:0]       cx_minus_y;
    logic signed [OUT_BITS-1:0]       cy_plus_x;
    logic signed [OUT_BITS-1:0]       cy_minus_x;
    logic                             final_step;

    int   chk_fails;
    int   chk_pending;
    int   beats_checked;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   circles_sent  = 0;
    int   cycle_count   = 0;
    int   hold_left     = 0;
    logic hold_req      = 1'b0;
    logic hold_seen     = 1'b0;

    midpoint_circle_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .circle_radius (circle_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cx_plus_x     (cx_plus_x),
        .cx_minus_x    (cx_minus_x),
        .cy_plus_y     (cy_plus_y),
        .cy_minus_y    (cy_minus_y),
        .cx_plus_y     (cx_plus_y),
        .cx_minus_y    (cx_minus_y),
        .cy_plus_x     (cy_plus_x),
        .cy_minus_x    (cy_minus_x),
        .final_step    (final_step)
    );

    octant_checker octant_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .circle_radius (circle_radius),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cx_plus_x     (cx_plus_x),
        .cx_minus_x    (cx_minus_x),
        .cy_plus_y     (cy_plus_y),
        .cy_minus_y    (cy_minus_y),
        .cx_plus_y     (cx_plus_y),
        .cx_minus_y    (cx_minus_y),
        .cy_plus_x     (cy_plus_x),
        .cy_minus_x    (cy_minus_x),
        .final_step    (final_step),
        .fails         (chk_fails),
        .pending       (chk_pending),
        .beats_checked (beats_checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: no finish after %0d cycles", CYCLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYC;
            out_stall <= 1'b1;
        end
        else
        begin
            if (!hold_req)
                hold_seen <= 1'b0;
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_circle(input int x, input int y, input int r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        centre_x      <= DEF_COORD_BITS'(x);
        centre_y      <= DEF_COORD_BITS'(y);
        circle_radius <= RADIUS_BITS'(r);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        circles_sent++;
    endtask

    // sender goes quiet until every expected point set has been seen
    task automatic drain_circles();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // mostly small circles, some full range including saturating radii
    function automatic int pick_radius();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return int'($urandom_range(20));
        else if (sel < 8)
            return int'($urandom_range(127));
        else
            return int'($urandom_range(127, 80));
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_circle(int'($urandom), int'($urandom), pick_radius());
    endtask

    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 62;
        send_circle(0, 0, 0);
        send_circle(0, 0, 1);
        send_circle(0, 0, 2);
        send_circle(0, 0, 3);
        send_circle(5, -7, 4);
        send_circle(-1024, -1024, 0);
        send_circle(1023, 1023, 0);
        send_circle(-1024, 1023, 88);
        send_circle(1023, -1024, 88);
        send_circle(1023, 1023, 88);
        send_circle(-1024, -1024, 88);
        send_circle(0, 0, 87);
        send_circle(0, 0, 89);
        send_circle(100, -100, 127);
        send_circle(-1024, 1023, 127);
        send_circle(-1, -1, 10);
        send_circle(300, 200, 5);
        send_circle(-512, 511, 64);
        send_circle(1, -2, 45);
        send_circle(0, 0, 100);
        send_circle(-683, 682, 85);
        send_circle(682, -683, 42);
        drain_circles();

        send_random(130);
        drain_circles();

        send_idle_pct = 62;
        recv_idle_pct = 33;
        send_random(120);
        drain_circles();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off while big circles keep arriving
        hold_req <= 1'b1;
        for (int i = 0; i < 6; i++)
            send_circle(int'($urandom), int'($urandom), 40);
        hold_req <= 1'b0;
        send_random(100);
        drain_circles();

        repeat (SETTLE_CYC) @(posedge clk);
        $display("tb: %0d circle requests sent, %0d octant beats checked", circles_sent,
                 beats_checked);
        $display("tb: radii 0..127 incl. saturation, centre extremes, mixed stalls, hold-off");
        if (chk_fails == 0 && chk_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_ctrl.sv
hw/rtl/mcr_datapath.sv
hw/rtl/midpoint_circle_rasterizer.sv
test/octant_checker.sv
test/tb.sv
